[src/eller_maze_row_generator_macros.svh]
// Assertion macros shared by the maze row generator checks.
`ifndef ELLER_MAZE_ROW_GENERATOR_MACROS_SVH
`define ELLER_MAZE_ROW_GENERATOR_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define EMRG_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("maze row generator port check failed");

// Clocked assertion that also holds through reset.
`define EMRG_ASSERT(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("maze row generator port check failed");

`endif

[src/emrg_pkg.sv]
// Shared types, constants and helpers of the maze row generator.
`default_nettype none

package emrg_pkg;

  // Column count and derived widths
  localparam int unsigned MaxWidth = 32;
  localparam int unsigned IdxW     = $clog2(MaxWidth);
  localparam int unsigned LabW     = IdxW + 1;
  localparam int unsigned CfgW     = 6;
  localparam int unsigned DataW    = 64;

  localparam logic [CfgW-1:0] WidthRst = CfgW'(MaxWidth);
  localparam logic [CfgW-1:0] WidthMin = CfgW'(2);
  localparam logic [CfgW-1:0] WidthMax = CfgW'(MaxWidth);

  // Operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_VERT,
    OP_HORZ,
    OP_COMP
  } op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_VERT,
    ST_HORZ,
    ST_COMP,
    ST_OUT
  } st_e;

  // Sequencer controls toward the datapath
  typedef struct packed {
    op_e  op;
    logic run;
    logic inject;
    logic load;
  } ctl_t;

  // Relabel request raised by the active cell
  typedef struct packed {
    logic            hit;
    logic [LabW-1:0] src_lab;
    logic [LabW-1:0] dst_lab;
  } bc_t;

  // Command seen by all cells in one cycle
  typedef struct packed {
    op_e             op;
    logic            run;
    logic            first;
    logic            last;
    logic            hit;
    logic [LabW-1:0] src_lab;
    logic [LabW-1:0] dst_lab;
  } cmd_t;

  // Limit the programmed width to the usable range
  function automatic logic [CfgW-1:0] clamp_width(input logic [CfgW-1:0] w);
    logic [CfgW-1:0] r;
    r = w;
    if (w < WidthMin) r = WidthMin;
    if (w > WidthMax) r = WidthMax;
    return r;
  endfunction

endpackage

`default_nettype wire

[src/emrg_cell.sv]
// One column cell: holds the column's set label and its opening bits.
`default_nettype none

module emrg_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  emrg_pkg::cmd_t            cmd_i,
  input  logic [emrg_pkg::IdxW-1:0] idx_i,
  input  logic                      used_i,
  input  logic                      is_last_i,
  input  logic                      down_bit_i,
  input  logic                      join_bit_i,
  input  logic                      tok_i,
  input  logic                      open_i,
  input  logic [emrg_pkg::LabW-1:0] nbr_lab_i,
  output logic                      tok_o,
  output logic                      open_o,
  output logic [emrg_pkg::LabW-1:0] lab_o,
  output logic                      keep_o,
  output logic                      join_o,
  output emrg_pkg::bc_t             bc_o
);
  import emrg_pkg::*;

  logic            tok_q;
  logic            open_q, open_d;
  logic            done_q, done_d;
  logic [LabW-1:0] lab_q, lab_d;
  logic            keep_q, keep_d;
  logic            join_q, join_d;

  logic            active, differ, run_end, take;
  logic            vert_act, horz_act, join_req, comp_act, matched;
  logic [LabW-1:0] own_lab, fresh_lab;

  assign own_lab   = {1'b0, idx_i};
  assign fresh_lab = {1'b1, idx_i};

  // Decide this cell's action and the next label
  always_comb begin
    active   = tok_q & used_i;
    differ   = (lab_q != nbr_lab_i);
    run_end  = is_last_i | differ;
    take     = down_bit_i | (run_end & ~open_i);
    vert_act = active & (cmd_i.op == OP_VERT);
    horz_act = active & ~is_last_i & (cmd_i.op == OP_HORZ);
    join_req = horz_act & differ & (join_bit_i | cmd_i.last);
    comp_act = active & ~done_q & (cmd_i.op == OP_COMP);
    matched  = cmd_i.hit & (lab_q == cmd_i.src_lab);

    // raise a relabel request: a join pulls the right set into ours,
    // compaction renames our set to this column index
    bc_o = '0;
    if (join_req) begin
      bc_o = '{hit: 1'b1, src_lab: nbr_lab_i, dst_lab: lab_q};
    end else if (comp_act) begin
      bc_o = '{hit: 1'b1, src_lab: lab_q, dst_lab: own_lab};
    end

    // a run stays open until its end column
    open_d = vert_act & ~run_end & (open_i | take);

    lab_d  = lab_q;
    keep_d = keep_q;
    join_d = join_q;
    done_d = done_q;
    case (cmd_i.op)
      OP_START: begin
        done_d = 1'b0;
        join_d = 1'b0;
        if (cmd_i.first | ~used_i) begin
          lab_d  = own_lab;
          keep_d = 1'b0;
        end
      end
      OP_VERT: begin
        if (vert_act) begin
          keep_d = take;
          if (!take) lab_d = fresh_lab;
        end
      end
      OP_HORZ: begin
        if (join_req) join_d = 1'b1;
        // merge only within the used columns
        if (matched & used_i) lab_d = cmd_i.dst_lab;
      end
      OP_COMP: begin
        if (matched & ~done_q) begin
          lab_d  = cmd_i.dst_lab;
          done_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Pass the token and the open-run flag to the right neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= 1'b0;
      open_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      tok_q  <= cmd_i.run & tok_i;
      open_q <= open_d;
      done_q <= done_d;
    end
  end

  // Hold label and opening bits
  always_ff @(posedge clk_i) begin
    lab_q  <= lab_d;
    keep_q <= keep_d;
    join_q <= join_d;
  end

  assign tok_o  = tok_q;
  assign open_o = open_q;
  assign lab_o  = lab_q;
  assign keep_o = keep_q;
  assign join_o = join_q;

endmodule

`default_nettype wire

[src/emrg_ctrl.sv]
// Row sequencer: walks the token through the vertical, join and compaction passes.
`default_nettype none

module emrg_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      first_i,
  input  logic [emrg_pkg::CfgW-1:0] w_i,
  input  logic                      out_free_i,
  output emrg_pkg::ctl_t            ctl_o,
  output logic                      idle_o
);
  import emrg_pkg::*;

  st_e             st_q, st_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [CfgW-1:0] w_m1;
  logic            at_m1;

  assign w_m1  = w_i - CfgW'(1);
  assign at_m1 = (cnt_q == w_m1[IdxW-1:0]);

  // Next state and controls
  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    ctl_o  = '{op: OP_NONE, run: 1'b0, inject: 1'b0, load: 1'b0};
    idle_o = 1'b0;
    case (st_q)
      ST_IDLE: begin
        idle_o = 1'b1;
        if (start_i) st_d = ST_START;
      end
      ST_START: begin
        ctl_o.op     = OP_START;
        ctl_o.run    = 1'b1;
        ctl_o.inject = 1'b1;
        cnt_d        = '0;
        st_d         = first_i ? ST_HORZ : ST_VERT;
      end
      ST_VERT: begin
        ctl_o.op  = OP_VERT;
        ctl_o.run = 1'b1;
        cnt_d     = cnt_q + IdxW'(1);
        if (at_m1) begin
          ctl_o.inject = 1'b1;
          cnt_d        = '0;
          st_d         = ST_HORZ;
        end
      end
      ST_HORZ: begin
        // walk all used columns so the token leaves the row before compaction
        ctl_o.op  = OP_HORZ;
        ctl_o.run = 1'b1;
        cnt_d     = cnt_q + IdxW'(1);
        if (at_m1) begin
          ctl_o.inject = 1'b1;
          cnt_d        = '0;
          st_d         = ST_COMP;
        end
      end
      ST_COMP: begin
        ctl_o.op  = OP_COMP;
        ctl_o.run = 1'b1;
        cnt_d     = cnt_q + IdxW'(1);
        if (at_m1) begin
          cnt_d = '0;
          st_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free_i) begin
          ctl_o.load = 1'b1;
          st_d       = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // State and column counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[src/eller_maze_row_generator.sv]
// Eller maze row generator top level: stream ports, width register and cell row.
// Each input beat carries one row's random bits and yields one output beat with
// that row's up openings and side openings. A row of column cells holds the set
// labels; a token walks across the used columns up to three times per row (vertical
// openings, side joins with set merging, label compaction), one column a cycle;
// the first row of a maze skips the vertical pass. The next beat is taken in the
// cycle after the result is loaded into the output register, even if the sink
// has not yet taken it; only one row is in work at a time, and a stalled sink
// holds a finished row until the output register frees up. The user must write
// the width only while the block is idle; the block itself does not enforce this.
`default_nettype none

module eller_maze_row_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config: used column count
  input  logic                         cfg_we_i,
  input  logic [emrg_pkg::CfgW-1:0]    cfg_wdata_i,
  // input row
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [emrg_pkg::DataW-1:0]   s_axis_tdata_i,  // down_random[31:0], join_random[62:32]
  input  logic                         s_axis_tlast_i,  // last_row
  // result row
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [emrg_pkg::DataW-1:0]   m_axis_tdata_o,  // down_open[31:0], join_open[62:32]
  output logic                         m_axis_tuser_o   // was_first_row
);
  import emrg_pkg::*;

  logic                  s_acc, idle, out_free;
  logic [CfgW-1:0]       width_q;
  logic                  at_first_q;
  logic [MaxWidth-1:0]   down_q;
  logic [MaxWidth-2:0]   join_in_q;
  logic                  last_q, first_q;
  logic [CfgW-1:0]       w_q;

  logic                  m_valid_q;
  logic [DataW-1:0]      m_data_q;
  logic                  m_user_q;

  ctl_t                  ctl;
  cmd_t                  cmd;
  bc_t                   bc_any;
  bc_t                   bc_w   [MaxWidth];
  logic [LabW-1:0]       lab_w  [MaxWidth];
  logic [MaxWidth-1:0]   tok_w, open_w, keep_w, join_w, used_w, is_last_w;

  assign s_acc           = s_axis_tvalid_i & s_axis_tready_o;
  assign s_axis_tready_o = idle;
  assign out_free        = ~m_valid_q | m_axis_tready_i;

  // Width register and first-row flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WidthRst;
      at_first_q <= 1'b1;
    end else begin
      if (cfg_we_i) width_q <= cfg_wdata_i;
      if (s_acc) at_first_q <= s_axis_tlast_i;
    end
  end

  // Capture the accepted beat
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      down_q    <= s_axis_tdata_i[MaxWidth-1:0];
      join_in_q <= s_axis_tdata_i[2*MaxWidth-2:MaxWidth];
      last_q    <= s_axis_tlast_i;
      first_q   <= at_first_q;
      w_q       <= clamp_width(width_q);
    end
  end

  emrg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s_acc),
    .first_i    (first_q),
    .w_i        (w_q),
    .out_free_i (out_free),
    .ctl_o      (ctl),
    .idle_o     (idle)
  );

  // Gather the request of the active cell
  always_comb begin
    bc_any = '0;
    for (int j = 0; j < MaxWidth; j++) begin
      bc_any = bc_t'(bc_any | bc_w[j]);
    end
  end

  // Broadcast command
  always_comb begin
    cmd.op      = ctl.op;
    cmd.run     = ctl.run;
    cmd.first   = first_q;
    cmd.last    = last_q;
    cmd.hit     = bc_any.hit;
    cmd.src_lab = bc_any.src_lab;
    cmd.dst_lab = bc_any.dst_lab;
  end

  // Row of column cells
  for (genvar j = 0; j < MaxWidth; j++) begin : g_cell
    logic            tok_in, open_in, join_bit;
    logic [LabW-1:0] nbr_lab;

    assign used_w[j]    = (CfgW'(j) < w_q);
    assign is_last_w[j] = (CfgW'(j) == CfgW'(w_q - CfgW'(1)));

    if (j == 0) begin : g_head
      assign tok_in  = ctl.inject;
      assign open_in = 1'b0;
    end else begin : g_body
      assign tok_in  = tok_w[j-1];
      assign open_in = open_w[j-1];
    end

    if (j == MaxWidth - 1) begin : g_tail
      assign nbr_lab  = '0;
      assign join_bit = 1'b0;
    end else begin : g_inner
      assign nbr_lab  = lab_w[j+1];
      assign join_bit = join_in_q[j];
    end

    emrg_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .idx_i      (IdxW'(j)),
      .used_i     (used_w[j]),
      .is_last_i  (is_last_w[j]),
      .down_bit_i (down_q[j]),
      .join_bit_i (join_bit),
      .tok_i      (tok_in),
      .open_i     (open_in),
      .nbr_lab_i  (nbr_lab),
      .tok_o      (tok_w[j]),
      .open_o     (open_w[j]),
      .lab_o      (lab_w[j]),
      .keep_o     (keep_w[j]),
      .join_o     (join_w[j]),
      .bc_o       (bc_w[j])
    );
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctl.load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (ctl.load) begin
      m_data_q <= {1'b0, join_w[MaxWidth-2:0], keep_w};
      m_user_q <= first_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

`default_nettype wire

[src/emrg_chk.sv]
// Port-level checks of the maze row generator and their binding.
`default_nettype none
`include "eller_maze_row_generator_macros.svh"

module emrg_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid_i,
  input logic                       s_axis_tready_i,
  input logic                       m_axis_tvalid_i,
  input logic                       m_axis_tready_i,
  input logic [emrg_pkg::DataW-1:0] m_axis_tdata_i,
  input logic                       m_axis_tuser_i
);
  import emrg_pkg::*;

  logic s_beat;
  assign s_beat = s_axis_tvalid_i & s_axis_tready_i;

  // Stalled result beat holds
  `EMRG_ASSERT_RST(a_out_hold, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))

  // One row in work at a time: input closes right after a beat
  `EMRG_ASSERT_RST(a_in_busy, clk_i, rst_ni, s_beat |=> !s_axis_tready_i && !$rose(m_axis_tvalid_i))

  // First row of a maze has no openings upward
  `EMRG_ASSERT(a_first_no_up, clk_i, m_axis_tvalid_i && m_axis_tuser_i |-> m_axis_tdata_i[MaxWidth-1:0] == '0)

  // Padding bit stays clear
  `EMRG_ASSERT(a_pad_zero, clk_i, m_axis_tvalid_i |-> !m_axis_tdata_i[DataW-1])

endmodule

bind eller_maze_row_generator emrg_chk u_emrg_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

`default_nettype wire
